/* hdl/cht_pkg.sv */
// cht_pkg: shared constants and types for the connection handshake table
// used by cht_ctl, cht_dp and connection_handshake_table; no dependencies
package cht_pkg;

  // default sizes, handed down from the top level
  localparam int ENTRIES_DEF   = 8;
  localparam int PORT_BITS_DEF = 16;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int SID_W    = 3;
  localparam int SEG_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 4;
  localparam int TMR_W    = 16;
  localparam int CST_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_OPEN       = 3'd0;
  localparam logic [OP_W-1:0] OP_CONNECT    = 3'd1;
  localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE      = 3'd3;
  localparam logic [OP_W-1:0] OP_SEGMENT    = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

  // connection states
  localparam logic [CST_W-1:0] CS_CLOSED    = 2'd0;
  localparam logic [CST_W-1:0] CS_SYNSENT   = 2'd1;
  localparam logic [CST_W-1:0] CS_CONNECTED = 2'd2;
  localparam logic [CST_W-1:0] CS_FINWAIT   = 2'd3;

  // segment types
  localparam logic [SEG_W-1:0] SEG_SYN    = 2'd0;
  localparam logic [SEG_W-1:0] SEG_SYNACK = 2'd1;
  localparam logic [SEG_W-1:0] SEG_FIN    = 2'd2;
  localparam logic [SEG_W-1:0] SEG_FINACK = 2'd3;

  // result kinds and report codes
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FAILED  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SENDS = 1'd1;
  localparam logic [TMR_W-1:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [CNT_W-1:0] MAX_SENDS_RST = 4'd5;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch;  // capture the input fields, clear per-item flags
    logic issue;  // read the entry on the index lines
    logic flush;  // release the held result as the final one
  } ctl_cmd_t;

endpackage

/* hdl/cht_ctl.sv */
// cht_ctl: sequencer that walks the table one entry a cycle per item
// depends on cht_pkg
module cht_ctl #(
  parameter int ENTRIES = cht_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cht_pkg::OP_W-1:0]   op,
  input  logic [cht_pkg::SID_W-1:0]  socket_id,
  output logic                       busy,
  output cht_pkg::ctl_cmd_t          cmd,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] idx
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] sid_idx, sid_idx_next;
  logic             single, single_next;

  // next state and command decode
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    sid_idx_next = sid_idx;
    single_next  = single;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch    = 1'b1;
          cnt_next     = '0;
          sid_idx_next = IDX_W'(socket_id);
          unique case (op) inside
            cht_pkg::OP_CONNECT, cht_pkg::OP_DISCONNECT, cht_pkg::OP_CLOSE: begin
              single_next = 1'b1;
              state_next  = S_SCAN;
            end
            cht_pkg::OP_OPEN, cht_pkg::OP_SEGMENT, cht_pkg::OP_TICK: begin
              single_next = 1'b0;
              state_next  = S_SCAN;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (single || cnt == LAST_IDX) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign idx  = single ? sid_idx : cnt;
  assign busy = (state != S_IDLE);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      single <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      single <= single_next;
    end
  end

  // entry address of a single-entry command
  always_ff @(posedge clk) begin
    sid_idx <= sid_idx_next;
  end

  // a tick or open operation keeps the block busy in the next cycle
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == cht_pkg::OP_TICK || op == cht_pkg::OP_OPEN)) |=> busy)
    else $error("tick or open accepted but block not busy");

  // the final release ends the item
  a_idle_after_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !busy)
    else $error("block still busy after flush");

  // a single-entry command walks exactly one entry
  a_single_one_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && single) |=> !cmd.issue)
    else $error("single-entry command issued more than one read");

endmodule

/* hdl/cht_dp.sv */
// cht_dp: entry table, port and timer stores, per-entry update and result staging
// depends on cht_pkg; driven by cht_ctl
module cht_dp #(
  parameter int ENTRIES   = cht_pkg::ENTRIES_DEF,
  parameter int PORT_BITS = cht_pkg::PORT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cht_pkg::ctl_cmd_t                 cmd,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] idx,
  input  logic [cht_pkg::OP_W-1:0]          op,
  input  logic [cht_pkg::SID_W-1:0]         socket_id,
  input  logic [PORT_BITS-1:0]              local_port,
  input  logic [PORT_BITS-1:0]              remote_port,
  input  logic [cht_pkg::SEG_W-1:0]         seg_type,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cht_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cht_pkg::CFG_W-1:0]         cfg_data,
  output logic                              result_valid,
  output logic                              kind,
  output logic [cht_pkg::SID_W-1:0]         entry_id,
  output logic [cht_pkg::STATUS_W-1:0]      status,
  output logic [cht_pkg::SEG_W-1:0]         out_type,
  output logic [PORT_BITS-1:0]              out_src_port,
  output logic [PORT_BITS-1:0]              out_dest_port,
  output logic                              last
);

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SID_W    = cht_pkg::SID_W;
  localparam int CNT_W    = cht_pkg::CNT_W;
  localparam int TMR_W    = cht_pkg::TMR_W;
  localparam int CST_W    = cht_pkg::CST_W;
  localparam int STATUS_W = cht_pkg::STATUS_W;
  localparam int SEG_W    = cht_pkg::SEG_W;

  // configuration registers
  logic [TMR_W-1:0] timeout_ticks;
  logic [CNT_W-1:0] max_sends;

  // captured item
  logic [cht_pkg::OP_W-1:0] op_r;
  logic [SID_W-1:0]         sid_r;
  logic [PORT_BITS-1:0]     lport_r, rport_r;
  logic [SEG_W-1:0]         stype_r;

  // entry flags with reset
  logic [ENTRIES-1:0] used;
  logic [CST_W-1:0]   cstate [ENTRIES];

  // stores written before use
  logic [PORT_BITS-1:0] client_mem [ENTRIES];
  logic [PORT_BITS-1:0] server_mem [ENTRIES];
  logic [CNT_W-1:0]     cnt_mem    [ENTRIES];
  logic [TMR_W-1:0]     tmr_mem    [ENTRIES];
  logic [PORT_BITS-1:0] client_rd, server_rd;
  logic [CNT_W-1:0]     cnt_rd;
  logic [TMR_W-1:0]     tmr_rd;

  // process stage
  logic             proc_v;
  logic [IDX_W-1:0] proc_idx;
  logic             hit;

  // held result, released when the next one arrives or at flush
  logic                 pend_v;
  logic                 p_kind;
  logic [SID_W-1:0]     p_id;
  logic [STATUS_W-1:0]  p_status;
  logic [SEG_W-1:0]     p_type;
  logic [PORT_BITS-1:0] p_src, p_dst;

  // per-entry update decisions
  logic                 used_p, sid_ok, valid_sel;
  logic [CST_W-1:0]     cst_p;
  logic [SID_W-1:0]     id_p;
  logic [TMR_W-1:0]     tmr_dec;
  logic                 used_we, used_wd, st_we;
  logic [CST_W-1:0]     st_wd;
  logic                 we_client, we_server, we_cnt, we_tmr;
  logic [CNT_W-1:0]     cnt_wd;
  logic [TMR_W-1:0]     tmr_wd;
  logic                 hit_set, prod;
  logic                 n_kind;
  logic [SID_W-1:0]     n_id;
  logic [STATUS_W-1:0]  n_status;
  logic [SEG_W-1:0]     n_type;
  logic [PORT_BITS-1:0] n_src, n_dst;

  assign cfg_ready = 1'b1;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= cht_pkg::TIMEOUT_RST;
      max_sends     <= cht_pkg::MAX_SENDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cht_pkg::REG_TIMEOUT:   timeout_ticks <= cfg_data[TMR_W-1:0];
        cht_pkg::REG_MAX_SENDS: max_sends     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the item at its transfer
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= op;
      sid_r   <= socket_id;
      lport_r <= local_port;
      rport_r <= remote_port;
      stype_r <= seg_type;
    end
  end

  // store reads, one entry per cycle while issue is high, and writes of the processed entry
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      client_rd <= client_mem[idx];
      server_rd <= server_mem[idx];
      cnt_rd    <= cnt_mem[idx];
      tmr_rd    <= tmr_mem[idx];
    end
    if (we_client) client_mem[proc_idx] <= lport_r;
    if (we_server) server_mem[proc_idx] <= rport_r;
    if (we_cnt)    cnt_mem[proc_idx]    <= cnt_wd;
    if (we_tmr)    tmr_mem[proc_idx]    <= tmr_wd;
  end

  // process stage follows the read in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_v <= 1'b0;
    end else begin
      proc_v <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= idx;
  end

  assign used_p    = used[proc_idx];
  assign cst_p     = cstate[proc_idx];
  assign id_p      = SID_W'(proc_idx);
  assign sid_ok    = (32'(sid_r) < 32'(ENTRIES));
  assign valid_sel = sid_ok && used_p;
  assign tmr_dec   = (tmr_rd != '0) ? (tmr_rd - TMR_W'(1)) : '0;

  // update of the entry under the process stage
  always_comb begin
    used_we   = 1'b0;
    used_wd   = 1'b0;
    st_we     = 1'b0;
    st_wd     = cht_pkg::CS_CLOSED;
    we_client = 1'b0;
    we_server = 1'b0;
    we_cnt    = 1'b0;
    we_tmr    = 1'b0;
    cnt_wd    = '0;
    tmr_wd    = '0;
    hit_set   = 1'b0;
    prod      = 1'b0;
    n_kind    = cht_pkg::KIND_REPORT;
    n_id      = id_p;
    n_status  = cht_pkg::STAT_OK;
    n_type    = cht_pkg::SEG_SYN;
    n_src     = '0;
    n_dst     = '0;
    if (proc_v) begin
      unique case (op_r)
        cht_pkg::OP_OPEN: begin
          // lowest free entry
          if (!hit && !used_p) begin
            used_we   = 1'b1;
            used_wd   = 1'b1;
            st_we     = 1'b1;
            st_wd     = cht_pkg::CS_CLOSED;
            we_client = 1'b1;
            we_cnt    = 1'b1;
            we_tmr    = 1'b1;
            hit_set   = 1'b1;
            prod      = 1'b1;
          end
        end
        cht_pkg::OP_CONNECT: begin
          prod = 1'b1;
          if (!valid_sel) begin
            n_id     = sid_r;
            n_status = cht_pkg::STAT_INVALID;
          end else begin
            we_server = 1'b1;
            st_we     = 1'b1;
            st_wd     = cht_pkg::CS_SYNSENT;
            we_cnt    = 1'b1;
            cnt_wd    = CNT_W'(1);
            we_tmr    = 1'b1;
            tmr_wd    = timeout_ticks;
            n_kind    = cht_pkg::KIND_SEGMENT;
            n_type    = cht_pkg::SEG_SYN;
            n_src     = client_rd;
            n_dst     = rport_r;
          end
        end
        cht_pkg::OP_DISCONNECT: begin
          prod = 1'b1;
          if (!valid_sel) begin
            n_id     = sid_r;
            n_status = cht_pkg::STAT_INVALID;
          end else begin
            st_we  = 1'b1;
            st_wd  = cht_pkg::CS_FINWAIT;
            we_cnt = 1'b1;
            cnt_wd = CNT_W'(1);
            we_tmr = 1'b1;
            tmr_wd = timeout_ticks;
            n_kind = cht_pkg::KIND_SEGMENT;
            n_type = cht_pkg::SEG_FIN;
            n_src  = client_rd;
            n_dst  = server_rd;
          end
        end
        cht_pkg::OP_CLOSE: begin
          prod = 1'b1;
          if (!valid_sel) begin
            n_id     = sid_r;
            n_status = cht_pkg::STAT_INVALID;
          end else if (cst_p == cht_pkg::CS_CLOSED) begin
            used_we = 1'b1;
            used_wd = 1'b0;
          end else begin
            n_status = cht_pkg::STAT_FAILED;
          end
        end
        cht_pkg::OP_SEGMENT: begin
          // first used entry with the same port pair decides
          if (!hit && used_p && client_rd == lport_r && server_rd == rport_r) begin
            hit_set = 1'b1;
            if (stype_r == cht_pkg::SEG_SYNACK && cst_p == cht_pkg::CS_SYNSENT) begin
              st_we = 1'b1;
              st_wd = cht_pkg::CS_CONNECTED;
              prod  = 1'b1;
            end else if (stype_r == cht_pkg::SEG_FINACK &&
                         cst_p == cht_pkg::CS_FINWAIT) begin
              st_we = 1'b1;
              st_wd = cht_pkg::CS_CLOSED;
              prod  = 1'b1;
            end
          end
        end
        cht_pkg::OP_TICK: begin
          if (used_p && (cst_p == cht_pkg::CS_SYNSENT || cst_p == cht_pkg::CS_FINWAIT)) begin
            we_tmr = 1'b1;
            tmr_wd = tmr_dec;
            if (tmr_dec == '0) begin
              prod = 1'b1;
              if (cnt_rd < max_sends) begin
                // resend and rearm
                we_cnt = 1'b1;
                cnt_wd = cnt_rd + CNT_W'(1);
                tmr_wd = timeout_ticks;
                n_kind = cht_pkg::KIND_SEGMENT;
                n_type = (cst_p == cht_pkg::CS_SYNSENT) ? cht_pkg::SEG_SYN
                                                         : cht_pkg::SEG_FIN;
                n_src  = client_rd;
                n_dst  = server_rd;
              end else begin
                // give up
                st_we    = 1'b1;
                st_wd    = cht_pkg::CS_CLOSED;
                n_status = cht_pkg::STAT_FAILED;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int e = 0; e < ENTRIES; e++) begin
        cstate[e] <= cht_pkg::CS_CLOSED;
      end
    end else begin
      if (used_we) used[proc_idx]   <= used_wd;
      if (st_we)   cstate[proc_idx] <= st_wd;
    end
  end

  // per-item control: match flag, held result, output strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      hit          <= 1'b0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.latch) begin
        hit    <= 1'b0;
        pend_v <= 1'b0;
      end else begin
        if (hit_set) hit <= 1'b1;
        if (cmd.flush) begin
          pend_v <= 1'b0;
          if (pend_v || (op_r == cht_pkg::OP_OPEN && !hit)) begin
            result_valid <= 1'b1;
          end
        end else if (prod) begin
          pend_v <= 1'b1;
          if (pend_v) result_valid <= 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      last <= 1'b1;
      if (pend_v) begin
        kind          <= p_kind;
        entry_id      <= p_id;
        status        <= p_status;
        out_type      <= p_type;
        out_src_port  <= p_src;
        out_dest_port <= p_dst;
      end else begin
        // table full report
        kind          <= cht_pkg::KIND_REPORT;
        entry_id      <= '0;
        status        <= cht_pkg::STAT_FULL;
        out_type      <= cht_pkg::SEG_SYN;
        out_src_port  <= '0;
        out_dest_port <= '0;
      end
    end else if (prod) begin
      last          <= 1'b0;
      kind          <= p_kind;
      entry_id      <= p_id;
      status        <= p_status;
      out_type      <= p_type;
      out_src_port  <= p_src;
      out_dest_port <= p_dst;
    end
    if (prod && !cmd.flush) begin
      p_kind   <= n_kind;
      p_id     <= n_id;
      p_status <= n_status;
      p_type   <= n_type;
      p_src    <= n_src;
      p_dst    <= n_dst;
    end
  end

  // the final result of an item is never followed at once by another
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result transfer right after a final one");

  // flush always empties the holding stage
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !pend_v)
    else $error("held result survived flush");

  // a new item starts with no match and nothing held
  a_latch_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (!pend_v && !hit))
    else $error("item started with stale match or held result");

  // only one entry of a connect or close command is processed
  a_one_per_cmd: assert property (@(posedge clk) disable iff (rst)
    (proc_v && (op_r == cht_pkg::OP_CONNECT || op_r == cht_pkg::OP_CLOSE)) |=> !proc_v)
    else $error("command processed more than one entry");

endmodule

/* hdl/connection_handshake_table.sv */
// connection_handshake_table: top level of the client-side connection table
// instantiates cht_ctl (sequencer) and cht_dp (table and result staging); uses cht_pkg
//
// Usage:
//   an item is taken when start is high and busy is low; op selects open,
//   connect, disconnect, close, received segment or tick
//   every item walks its entries through the stores one entry per cycle:
//   open, segment and tick visit all ENTRIES, connect, disconnect and close
//   visit the addressed entry only
//   busy stays high while an item walks its entries and through the drain and
//   flush states after it, so a new item is taken only when the last is done;
//   an unknown op is taken without raising busy and gives nothing
//   results come one per cycle at most on result_valid, each for one cycle,
//   in entry order, the final one of an item marked by last; the final one
//   appears in the same cycle that busy falls
//   the receiver cannot hold results off
//   configuration writes on cfg_valid/cfg_ready are always taken and are meant
//   for idle periods only
//   rst (synchronous) closes and frees every entry and loads the timeout of
//   1000 ticks and the limit of 5 transmissions
module connection_handshake_table #(
  parameter int ENTRIES   = cht_pkg::ENTRIES_DEF,
  parameter int PORT_BITS = cht_pkg::PORT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cht_pkg::OP_W-1:0]      op,
  input  logic [cht_pkg::SID_W-1:0]     socket_id,
  input  logic [PORT_BITS-1:0]          local_port,
  input  logic [PORT_BITS-1:0]          remote_port,
  input  logic [cht_pkg::SEG_W-1:0]     seg_type,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cht_pkg::CFG_W-1:0]     cfg_data,
  output logic                          result_valid,
  output logic                          kind,
  output logic [cht_pkg::SID_W-1:0]     entry_id,
  output logic [cht_pkg::STATUS_W-1:0]  status,
  output logic [cht_pkg::SEG_W-1:0]     out_type,
  output logic [PORT_BITS-1:0]          out_src_port,
  output logic [PORT_BITS-1:0]          out_dest_port,
  output logic                          last
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cht_pkg::ctl_cmd_t cmd;
  logic [IDX_W-1:0]  idx;

  // sequencer
  cht_ctl #(
    .ENTRIES (ENTRIES)
  ) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .socket_id (socket_id),
    .busy      (busy),
    .cmd       (cmd),
    .idx       (idx)
  );

  // table and result path
  cht_dp #(
    .ENTRIES   (ENTRIES),
    .PORT_BITS (PORT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .idx           (idx),
    .op            (op),
    .socket_id     (socket_id),
    .local_port    (local_port),
    .remote_port   (remote_port),
    .seg_type      (seg_type),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .kind          (kind),
    .entry_id      (entry_id),
    .status        (status),
    .out_type      (out_type),
    .out_src_port  (out_src_port),
    .out_dest_port (out_dest_port),
    .last          (last)
  );

endmodule
